[src/dspm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dspm_pkg
// Shared widths, scale constants and the divider request type for the
// dual-signal period, duty and phase meter.
// ----------------------------------------------------------------------------
package dspm_pkg;

  localparam int TS_W   = 32;
  localparam int NUM_W  = 48;
  localparam int DEN_W  = 32;
  localparam int FREQ_W = 39;
  localparam int RES_W  = 16;
  localparam int CNT_W  = $clog2(NUM_W);

  localparam logic [NUM_W-1:0] CENTI       = 48'd100;
  localparam logic [NUM_W-1:0] DUTY_SCALE  = 48'd10000;
  localparam logic [NUM_W-1:0] PHASE_SCALE = 48'd36000;
  localparam logic [RES_W-1:0] SAT16       = 16'hFFFF;
  localparam logic [TS_W-1:0]  TICK_RESET  = 32'd1000000;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

endpackage : dspm_pkg
`default_nettype wire

[src/dspm_divider.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dspm_divider
// Radix-2 restoring divider, one quotient bit per cycle, NUM_W steps.
// ----------------------------------------------------------------------------
module dspm_divider
  import dspm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire div_req_t         req,
  output logic                  done,
  output logic [NUM_W-1:0]      quotient
);

  logic [NUM_W-1:0] num_sh;
  logic [DEN_W-1:0] den;
  logic [DEN_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             qbit;

  assign trial    = {rem, num_sh[NUM_W-1]};
  assign diff     = trial - {1'b0, den};
  assign qbit     = ~diff[DEN_W];
  assign quotient = num_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy   <= 1'b1;
        cnt    <= '0;
        num_sh <= req.num;
        den    <= req.den;
        rem    <= '0;
      end else if (busy) begin
        num_sh <= {num_sh[NUM_W-2:0], qbit};
        rem    <= qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        cnt    <= cnt + 1'b1;
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule : dspm_divider
`default_nettype wire

[src/dual_signal_period_duty_phase_meter_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dual_signal_period_duty_phase_meter_top
// Period, pulse width, frequency, duty and phase meter for two signals fed
// by input-capture beats.
// ----------------------------------------------------------------------------
// Each capture beat updates the stored edge times of its signal and is
// followed by up to two divisions on one shared 48-step radix-2 divider: the
// frequency (rising edge) or duty (falling edge), then the phase of signal 1
// against signal 0. A zero divisor skips its pass. s_tready is low while a
// beat is being worked on; a finished result waits in the output register
// while the next beat is taken, and a second finished result holds s_tready
// low until the output register is free. tick_rate_hz sits at byte address 0
// and resets to 1000000.
module dual_signal_period_duty_phase_meter_top
  import dspm_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [31:0]  s_tdata,   // timestamp
  input  wire logic [1:0]   s_tuser,   // signal_index, falling_edge
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [135:0]      m_tdata,   // period_ticks, width_ticks, frequency_centihz,
                                       // duty_centipercent, phase_centidegrees, pad
  output logic [2:0]        m_tuser    // report_signal, divide_by_zero, saturated
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_UPD, ST_MUL, ST_DIV, ST_PMUL, ST_PDIV, ST_OUT
  } state_t;

  state_t            state;
  logic [TS_W-1:0]   tick_rate_hz;
  logic [TS_W-1:0]   rise_time [2];
  logic [TS_W-1:0]   fall_time [2];
  logic [TS_W-1:0]   period_store [2];
  logic [TS_W-1:0]   width_store [2];
  logic [FREQ_W-1:0] frequency_store [2];
  logic [RES_W-1:0]  duty_store [2];
  logic [RES_W-1:0]  phase;
  logic              cur_sig;
  logic              cur_fall;
  logic [TS_W-1:0]   cur_ts;
  logic              dz;
  logic              sat;
  div_req_t          div_req;
  logic              div_done;
  logic [NUM_W-1:0]  quo;
  logic [TS_W-1:0]   delta;
  logic              quo_big;
  logic              cfg_wr;

  dspm_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (quo)
  );

  assign pready   = 1'b1;
  assign cfg_wr   = psel & penable & pwrite & pready;
  assign prdata   = paddr[2] ? 32'd0 : tick_rate_hz;
  assign s_tready = (state == ST_IDLE);
  assign delta    = rise_time[1] - rise_time[0];
  assign quo_big  = |quo[NUM_W-1:RES_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_rate_hz <= TICK_RESET;
    end else if (cfg_wr && !paddr[2]) begin
      tick_rate_hz <= pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_tvalid      <= 1'b0;
      div_req.start <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        rise_time[i]       <= '0;
        fall_time[i]       <= '0;
        period_store[i]    <= '0;
        width_store[i]     <= '0;
        frequency_store[i] <= '0;
        duty_store[i]      <= '0;
      end
    end else begin
      div_req.start <= 1'b0;
      if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            cur_sig  <= s_tuser[0];
            cur_fall <= s_tuser[1];
            cur_ts   <= s_tdata;
            dz       <= 1'b0;
            sat      <= 1'b0;
            state    <= ST_UPD;
          end
        end
        ST_UPD: begin
          if (!cur_fall) begin
            period_store[cur_sig] <= cur_ts - rise_time[cur_sig];
            rise_time[cur_sig]    <= cur_ts;
          end else begin
            fall_time[cur_sig]   <= cur_ts;
            width_store[cur_sig] <= cur_ts - rise_time[cur_sig];
          end
          state <= ST_MUL;
        end
        ST_MUL: begin
          div_req.num <= !cur_fall
                         ? {{(NUM_W-TS_W){1'b0}}, tick_rate_hz} * CENTI
                         : {{(NUM_W-TS_W){1'b0}}, width_store[cur_sig]} * DUTY_SCALE;
          div_req.den <= period_store[cur_sig];
          if (period_store[cur_sig] == '0) begin
            dz <= 1'b1;
            if (!cur_fall) begin
              frequency_store[cur_sig] <= '0;
            end else begin
              duty_store[cur_sig] <= '0;
            end
            state <= ST_PMUL;
          end else begin
            div_req.start <= 1'b1;
            state         <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            if (!cur_fall) begin
              frequency_store[cur_sig] <= quo[FREQ_W-1:0];
            end else begin
              duty_store[cur_sig] <= quo_big ? SAT16 : quo[RES_W-1:0];
              if (quo_big) begin
                sat <= 1'b1;
              end
            end
            state <= ST_PMUL;
          end
        end
        ST_PMUL: begin
          div_req.num <= {{(NUM_W-TS_W){1'b0}}, delta} * PHASE_SCALE;
          div_req.den <= period_store[0];
          if (period_store[0] == '0) begin
            dz    <= 1'b1;
            phase <= '0;
            state <= ST_OUT;
          end else begin
            div_req.start <= 1'b1;
            state         <= ST_PDIV;
          end
        end
        ST_PDIV: begin
          if (div_done) begin
            phase <= quo_big ? SAT16 : quo[RES_W-1:0];
            if (quo_big) begin
              sat <= 1'b1;
            end
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {1'b0, phase, duty_store[cur_sig], frequency_store[cur_sig],
                         width_store[cur_sig], period_store[cur_sig]};
            m_tuser  <= {sat, dz, cur_sig};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule : dual_signal_period_duty_phase_meter_top
`default_nettype wire
